/* src/ffba_pkg.sv */
package ffba_pkg;

    // payload field widths
    localparam int ACTION_W = 2;
    localparam int LEN_W    = 8;
    localparam int EID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int BID_W    = 16;
    localparam int SIZE_W   = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEFRAG = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_FILL   = 6'b001000,
        S_ZERO   = 6'b010000,
        S_FINISH = 6'b100000
    } seq_state_t;

endpackage

/* src/ffba_req_if.sv */
interface ffba_req_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::ACTION_W-1:0]  action;
    logic [ffba_pkg::LEN_W-1:0]     request_length;
    logic [ffba_pkg::EID_W-1:0]     erase_id;

    modport source (
        output valid, action, request_length, erase_id,
        input  ready
    );

    modport sink (
        input  valid, action, request_length, erase_id,
        output ready
    );
endinterface

/* src/ffba_rsp_if.sv */
interface ffba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::BID_W-1:0]     block_id;

    modport source (
        output valid, status, block_id,
        input  ready
    );

    modport sink (
        input  valid, status, block_id,
        output ready
    );
endinterface

/* src/first_fit_block_allocator_top.sv */
// Alloc and erase reject bad requests up front. Otherwise alloc scans the cells for a
// free run and marks it with the new id, erase scans the cells in use, and defragment
// compacts them and zeroes the tail. One word in flight; the shared scan/compare path
// and the single RAM write port set the rate, roughly one cell per cycle per pass.
// Reset: asynchronous, active low; after it the cell RAM is zeroed, one cell a cycle,
// during which no word is taken. Size register resets to 128.
module first_fit_block_allocator_top #(
    parameter int MEM_CELLS = 128,
    parameter int ID_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ffba_pkg::SIZE_W-1:0] cfg_wdata,
    ffba_req_if.sink                    req,
    ffba_rsp_if.source                  rsp
);

    localparam int CNT_W = $clog2(MEM_CELLS + 1);
    localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;
    localparam int SZ_W = (CNT_W > ffba_pkg::SIZE_W) ? CNT_W : ffba_pkg::SIZE_W;

    logic [ffba_pkg::SIZE_W-1:0] memory_size_reg, memory_size_next;
    logic [CNT_W-1:0]            size;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ID_BITS-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ID_BITS-1:0] ram_rdata;

    assign memory_size_next = cfg_we ? cfg_wdata : memory_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= ffba_pkg::SIZE_RESET;
        end
        else
        begin
            memory_size_reg <= memory_size_next;
        end
    end

    // cells in use: min(memory_size, MEM_CELLS)
    assign size = (SZ_W'(memory_size_reg) >= SZ_W'(MEM_CELLS)) ?
                  CNT_W'(MEM_CELLS) : CNT_W'(memory_size_reg);

    ffba_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (MEM_CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffba_seq #(
        .MEM_CELLS (MEM_CELLS),
        .ID_BITS   (ID_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

/* src/ffba_ram.sv */
module ffba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/ffba_seq.sv */
module ffba_seq #(
    parameter int MEM_CELLS = 128,
    parameter int ID_BITS = 16,
    localparam int CNT_W = $clog2(MEM_CELLS + 1),
    localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   size,
    ffba_req_if.sink           req,
    ffba_rsp_if.source         rsp,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [ID_BITS-1:0] ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [ID_BITS-1:0] ram_rdata
);

    localparam int W  = (ID_BITS > ffba_pkg::EID_W) ? ID_BITS : ffba_pkg::EID_W;
    localparam int LW = (CNT_W > ffba_pkg::LEN_W) ? CNT_W : ffba_pkg::LEN_W;
    localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

    ffba_pkg::seq_state_t state_reg, state_next;

    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic               pend_reg, pend_next;
    logic [ID_BITS-1:0] last_id_reg, last_id_next;
    logic               res_has_reg, res_has_next;
    logic               out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [ffba_pkg::ACTION_W-1:0] mode_reg, mode_next;
    logic               found_reg, found_next;
    logic [ffba_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ffba_pkg::BID_W-1:0]    res_id_reg, res_id_next;
    logic [ffba_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ffba_pkg::BID_W-1:0]    out_id_reg, out_id_next;

    always_comb
    begin
        logic [CNT_W-1:0]   run_inc;
        logic [CNT_W-1:0]   run_start;
        logic [ID_BITS-1:0] new_id;
        logic [W-1:0]       eid_w;
        logic [W-1:0]       new_id_w;

        state_next      = state_reg;
        wr_next         = wr_reg;
        pend_next       = pend_reg;
        last_id_next    = last_id_reg;
        res_has_next    = res_has_reg;
        out_valid_next  = out_valid_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        id_next         = id_reg;
        mode_next       = mode_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_reg[AW-1:0];
        ram_wdata = '0;
        ram_raddr = addr_reg[AW-1:0];

        req.ready = (state_reg == ffba_pkg::S_IDLE);

        run_inc   = run_reg + 1'b1;
        run_start = (run_reg == '0) ? idx_reg : start_reg;
        new_id    = last_id_reg + 1'b1;
        eid_w     = W'(req.erase_id);
        new_id_w  = W'(new_id);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ffba_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_reg[AW-1:0];
                wr_next   = wr_reg + 1'b1;
                if (wr_reg == CNT_W'(MEM_CELLS - 1))
                begin
                    wr_next    = '0;
                    state_next = ffba_pkg::S_IDLE;
                end
            end

            ffba_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next    = req.action;
                    addr_next    = '0;
                    pend_next    = 1'b0;
                    res_has_next = 1'b0;
                    res_id_next  = '0;
                    case (req.action)
                        ffba_pkg::ACT_ALLOC:
                        begin
                            if ((req.request_length == '0) ||
                                (LW'(req.request_length) > LW'(size)) ||
                                (last_id_reg == ID_MAX))
                            begin
                                res_has_next    = 1'b1;
                                res_status_next = ffba_pkg::ST_NULL;
                                state_next      = ffba_pkg::S_FINISH;
                            end
                            else
                            begin
                                run_next   = '0;
                                len_next   = CNT_W'(req.request_length);
                                state_next = ffba_pkg::S_SCAN;
                            end
                        end
                        ffba_pkg::ACT_ERASE:
                        begin
                            if ((req.erase_id == '0) || (eid_w > W'(last_id_reg)))
                            begin
                                res_has_next    = 1'b1;
                                res_status_next = ffba_pkg::ST_ILLEGAL;
                                state_next      = ffba_pkg::S_FINISH;
                            end
                            else
                            begin
                                id_next    = eid_w[ID_BITS-1:0];
                                found_next = 1'b0;
                                state_next = ffba_pkg::S_SCAN;
                            end
                        end
                        ffba_pkg::ACT_DEFRAG:
                        begin
                            wr_next    = '0;
                            state_next = ffba_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = ffba_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            ffba_pkg::S_SCAN:
            begin
                // read one cell ahead; the compare works on last cycle's read
                if (addr_reg < size)
                begin
                    pend_next = 1'b1;
                    idx_next  = addr_reg;
                    addr_next = addr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    case (mode_reg)
                        ffba_pkg::ACT_ALLOC:
                        begin
                            if (ram_rdata != '0)
                            begin
                                run_next = '0;
                            end
                            else if (run_inc >= len_reg)
                            begin
                                // run found: fill start..idx
                                wr_next    = run_start;
                                addr_next  = idx_reg;
                                pend_next  = 1'b0;
                                state_next = ffba_pkg::S_FILL;
                            end
                            else
                            begin
                                run_next   = run_inc;
                                start_next = run_start;
                            end
                        end
                        ffba_pkg::ACT_ERASE:
                        begin
                            if (ram_rdata == id_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = idx_reg[AW-1:0];
                                ram_wdata  = '0;
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (ram_rdata != '0)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = wr_reg[AW-1:0];
                                ram_wdata = ram_rdata;
                                wr_next   = wr_reg + 1'b1;
                            end
                        end
                    endcase
                end
                else if (addr_reg >= size)
                begin
                    case (mode_reg)
                        ffba_pkg::ACT_ALLOC:
                        begin
                            res_has_next    = 1'b1;
                            res_status_next = ffba_pkg::ST_NULL;
                            state_next      = ffba_pkg::S_FINISH;
                        end
                        ffba_pkg::ACT_ERASE:
                        begin
                            res_has_next    = !found_reg;
                            res_status_next = ffba_pkg::ST_ILLEGAL;
                            state_next      = ffba_pkg::S_FINISH;
                        end
                        default:
                        begin
                            state_next = ffba_pkg::S_ZERO;
                        end
                    endcase
                end
            end

            ffba_pkg::S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_reg[AW-1:0];
                ram_wdata = new_id;
                wr_next   = wr_reg + 1'b1;
                if (wr_reg == addr_reg)
                begin
                    last_id_next    = new_id;
                    res_has_next    = 1'b1;
                    res_status_next = ffba_pkg::ST_OK;
                    res_id_next     = new_id_w[ffba_pkg::BID_W-1:0];
                    state_next      = ffba_pkg::S_FINISH;
                end
            end

            ffba_pkg::S_ZERO:
            begin
                if (wr_reg < size)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[AW-1:0];
                    ram_wdata = '0;
                    wr_next   = wr_reg + 1'b1;
                end
                else
                begin
                    state_next = ffba_pkg::S_FINISH;
                end
            end

            ffba_pkg::S_FINISH:
            begin
                if (!res_has_reg)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
                else if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    res_has_next    = 1'b0;
                    state_next      = ffba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::S_CLEAR;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            last_id_reg   <= '0;
            res_has_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            last_id_reg   <= last_id_next;
            res_has_reg   <= res_has_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        id_reg         <= id_next;
        mode_reg       <= mode_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.block_id = out_id_reg;

    a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffba_pkg::S_FILL |-> wr_reg <= addr_reg)
        else $error("fill pointer passed end of run");

    a_compact_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffba_pkg::S_SCAN) && (mode_reg == ffba_pkg::ACT_DEFRAG) && pend_reg
        |-> wr_reg <= idx_reg)
        else $error("compaction write pointer ahead of read");

    a_id_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ffba_pkg::S_FILL |=> last_id_reg == $past(last_id_reg))
        else $error("id counter moved outside fill");

    a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ffba_pkg::ST_OK) |-> out_id_reg == '0)
        else $error("failed word carries nonzero id");

endmodule

/* sim/first_fit_block_allocator_top_test.sv */
module first_fit_block_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_CELLS = 128;
    localparam int ID_BITS   = 16;
    localparam int ID_LIMIT  = (1 << ID_BITS) - 1;
    localparam int SETTLE    = 300;   // beyond the longest defragment pass
    localparam int ID_PAIRS  = 75;

    // code 3 is not decoded by the block
    localparam logic [ffba_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ffba_pkg::ACTION_W-1:0] action;
        logic [ffba_pkg::LEN_W-1:0]    len;
        logic [ffba_pkg::EID_W-1:0]    eid;
    } op_word_t;

    typedef struct packed {
        logic [ffba_pkg::STATUS_W-1:0] status;
        logic [ffba_pkg::BID_W-1:0]    block_id;
    } reply_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [ffba_pkg::SIZE_W-1:0]   cfg_wdata = '0;

    logic                          req_valid  = 1'b0;
    logic [ffba_pkg::ACTION_W-1:0] req_action = '0;
    logic [ffba_pkg::LEN_W-1:0]    req_len    = '0;
    logic [ffba_pkg::EID_W-1:0]    req_eid    = '0;
    logic                          rsp_ready  = 1'b0;

    ffba_req_if req_bus ();
    ffba_rsp_if rsp_bus ();

    assign req_bus.valid          = req_valid;
    assign req_bus.action         = req_action;
    assign req_bus.request_length = req_len;
    assign req_bus.erase_id       = req_eid;
    assign rsp_bus.ready          = rsp_ready;

    first_fit_block_allocator_top #(
        .MEM_CELLS (MEM_CELLS),
        .ID_BITS   (ID_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // allocator image kept by the bench
    logic [ID_BITS-1:0]          own_tbl [MEM_CELLS];
    logic [ID_BITS-1:0]          id_ctr;
    logic [ffba_pkg::SIZE_W-1:0] size_reg;
    reply_t                      replies_due [$];

    op_word_t pending [$];
    int       queued_cnt = 0;
    int       taken_cnt  = 0;
    int       bad_cnt    = 0;
    bit       idle_on    = 1'b1;
    int       drv_wait   = 0;
    int       rsp_wait   = 0;
    logic     req_took   = 1'b0;
    logic     rsp_took   = 1'b0;

    initial
    begin
        for (int i = 0; i < MEM_CELLS; i++)
            own_tbl[i] = '0;
        id_ctr   = '0;
        size_reg = ffba_pkg::SIZE_RESET;
    end

    function automatic int gap_len();
        return idle_on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    task automatic log_fault(input string msg);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic run_request(input op_word_t w);
        int     span;
        int     run;
        int     start;
        int     wr;
        bit     done;
        bit     found;
        reply_t r;
        span = (int'(size_reg) < MEM_CELLS) ? int'(size_reg) : MEM_CELLS;
        case (w.action)
            ffba_pkg::ACT_ALLOC:
            begin
                r.status   = ffba_pkg::ST_NULL;
                r.block_id = '0;
                if (w.len != 0 && int'(w.len) <= span && int'(id_ctr) != ID_LIMIT)
                begin
                    run  = 0;
                    done = 1'b0;
                    for (int i = 0; i < span && !done; i++)
                    begin
                        if (own_tbl[i] != 0)
                            run = 0;
                        else
                        begin
                            if (run == 0)
                                start = i;
                            run++;
                            if (run >= int'(w.len))
                            begin
                                id_ctr = id_ctr + 1'b1;
                                for (int j = start; j < start + int'(w.len); j++)
                                    own_tbl[j] = id_ctr;
                                r.status   = ffba_pkg::ST_OK;
                                r.block_id = id_ctr;
                                done       = 1'b1;
                            end
                        end
                    end
                end
                replies_due.push_back(r);
            end
            ffba_pkg::ACT_ERASE:
            begin
                found = 1'b0;
                if (w.eid != 0 && w.eid <= id_ctr)
                begin
                    for (int i = 0; i < span; i++)
                    begin
                        if (own_tbl[i] == w.eid)
                        begin
                            own_tbl[i] = '0;
                            found      = 1'b1;
                        end
                    end
                end
                if (!found)
                    replies_due.push_back('{ffba_pkg::ST_ILLEGAL, '0});
            end
            ffba_pkg::ACT_DEFRAG:
            begin
                wr = 0;
                for (int i = 0; i < span; i++)
                begin
                    if (own_tbl[i] != 0)
                    begin
                        own_tbl[wr] = own_tbl[i];
                        wr++;
                    end
                end
                for (int i = wr; i < span; i++)
                    own_tbl[i] = '0;
            end
            default: ;
        endcase
    endtask

    // sampling, prediction and checking
    always @(posedge clk)
    begin
        req_took <= rst_n && req_bus.valid && req_bus.ready;
        rsp_took <= rst_n && rsp_bus.valid && rsp_bus.ready;
        if (rst_n)
        begin
            if (cfg_we)
                size_reg = cfg_wdata;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (replies_due.size() == 0)
                    log_fault($sformatf("unexpected word: status %0d block_id %0d",
                                        rsp_bus.status, rsp_bus.block_id));
                else
                begin
                    reply_t e;
                    e = replies_due.pop_front();
                    if (rsp_bus.status !== e.status || rsp_bus.block_id !== e.block_id)
                        log_fault($sformatf(
                            "mismatch: status exp %0d got %0d, block_id exp %0d got %0d",
                            e.status, rsp_bus.status, e.block_id, rsp_bus.block_id));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                run_request('{req_bus.action, req_bus.request_length, req_bus.erase_id});
                taken_cnt++;
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_took)
        begin
            if (pending.size() == 0)
                req_valid <= 1'b0;
            else if (drv_wait > 0)
            begin
                drv_wait--;
                req_valid <= 1'b0;
            end
            else
            begin
                op_word_t w;
                w = pending.pop_front();
                req_action <= w.action;
                req_len    <= w.len;
                req_eid    <= w.eid;
                req_valid  <= 1'b1;
                drv_wait   = gap_len();
            end
        end
    end

    // reply side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_took)
                rsp_wait = gap_len();
            if (rsp_wait > 0)
            begin
                rsp_wait--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic queue_word(input logic [ffba_pkg::ACTION_W-1:0] act, input int len,
                              input int eid);
        op_word_t w;
        w.action = act;
        w.len    = len[ffba_pkg::LEN_W-1:0];
        w.eid    = eid[ffba_pkg::EID_W-1:0];
        pending.push_back(w);
        queued_cnt++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (taken_cnt != queued_cnt || replies_due.size() != 0);
    endtask

    task automatic set_size(input logic [ffba_pkg::SIZE_W-1:0] v);
        wait_quiet();
        // successful erase and defragment give no word back, let them finish
        repeat (SETTLE) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic int pick_owner(input int lim);
        int hits [$];
        for (int i = 0; i < lim; i++)
            if (own_tbl[i] != 0)
                hits.push_back(i);
        if (hits.size() == 0)
            return -1;
        return int'(own_tbl[hits[$urandom_range(0, hits.size() - 1)]]);
    endfunction

    task automatic queue_random_word();
        int                            eff;
        int                            roll;
        int                            len;
        int                            eid;
        logic [ffba_pkg::ACTION_W-1:0] act;
        // hold until the image is current so erase ids can target live blocks
        do
            @(negedge clk);
        while (taken_cnt != queued_cnt);
        eff  = (int'(size_reg) < MEM_CELLS) ? int'(size_reg) : MEM_CELLS;
        roll = $urandom_range(0, 99);
        act  = (roll < 46) ? ffba_pkg::ACT_ALLOC : (roll < 80) ? ffba_pkg::ACT_ERASE :
               (roll < 95) ? ffba_pkg::ACT_DEFRAG : ACT_UNUSED;
        len  = $urandom_range(0, 255);
        eid  = $urandom_range(0, 65535);
        if (act == ffba_pkg::ACT_ALLOC)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
                len = $urandom_range(1, (eff > 12) ? 12 : ((eff < 2) ? 2 : eff));
            else if (roll == 7)
                len = 0;
            else if (roll == 8)
                len = $urandom_range(1, 128);
        end
        else if (act == ffba_pkg::ACT_ERASE)
        begin
            roll = $urandom_range(0, 19);
            if (roll < 11)
                eid = pick_owner(eff);
            else if (roll == 11)
                eid = pick_owner(MEM_CELLS);
            else if (roll < 14)
                eid = 0;
            else if (roll < 16 && int'(id_ctr) != 0)
                eid = $urandom_range(1, int'(id_ctr));
            else if (roll < 18 && int'(id_ctr) != ID_LIMIT)
                eid = $urandom_range(int'(id_ctr) + 1, ID_LIMIT);
            if (eid < 0)
                eid = $urandom_range(0, 65535);
        end
        queue_word(act, len, eid);
    endtask

    initial
    begin
        int sizes [11] = '{8, 1, 128, 5, 0, 32, 255, 12, 3, 200, 20};
        int id_base;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_size(8'd128);
        queue_word(ffba_pkg::ACT_ALLOC, 0, $urandom);
        queue_word(ffba_pkg::ACT_ALLOC, 128, $urandom);      // whole store
        queue_word(ffba_pkg::ACT_ALLOC, 1, $urandom);        // no room left
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 0);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 2);        // not handed out yet
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 1);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 1);        // already freed
        queue_word(ffba_pkg::ACT_ALLOC, 255, $urandom);
        queue_word(ffba_pkg::ACT_ALLOC, 3, $urandom);
        queue_word(ffba_pkg::ACT_ALLOC, 5, $urandom);
        queue_word(ffba_pkg::ACT_ALLOC, 2, $urandom);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 3);        // hole in the middle
        queue_word(ffba_pkg::ACT_DEFRAG, $urandom, $urandom);
        queue_word(ffba_pkg::ACT_ALLOC, 7, $urandom);
        queue_word(ACT_UNUSED, $urandom, $urandom);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, ID_LIMIT);
        // shrink: block 5 sits past the end, block 4 straddles it
        set_size(8'd4);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 5);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 4);
        queue_word(ffba_pkg::ACT_ALLOC, 1, $urandom);
        set_size(8'd0);
        queue_word(ffba_pkg::ACT_ALLOC, 1, $urandom);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 2);
        set_size(8'd200);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, 4);
        queue_word(ffba_pkg::ACT_DEFRAG, $urandom, $urandom);
        queue_word(ffba_pkg::ACT_ALLOC, 128, $urandom);

        foreach (sizes[p])
        begin
            set_size(sizes[p][ffba_pkg::SIZE_W-1:0]);
            idle_on = (p % 3 != 2);
            repeat ((sizes[p] == 0) ? 30 : 165) queue_random_word();
        end

        // back-to-back alloc/erase pairs on one cell
        set_size(8'd1);
        idle_on = 1'b0;
        wait_quiet();
        if (own_tbl[0] != 0)
        begin
            queue_word(ffba_pkg::ACT_ERASE, $urandom, int'(own_tbl[0]));
            wait_quiet();
        end
        id_base = int'(id_ctr);
        for (int k = id_base + 1; k <= id_base + ID_PAIRS; k++)
        begin
            queue_word(ffba_pkg::ACT_ALLOC, 1, $urandom);
            queue_word(ffba_pkg::ACT_ERASE, $urandom, k);
        end
        queue_word(ffba_pkg::ACT_ALLOC, 1, $urandom);
        queue_word(ffba_pkg::ACT_ERASE, $urandom, ID_LIMIT);
        queue_word(ffba_pkg::ACT_ALLOC, 0, $urandom);

        set_size(8'd128);
        idle_on = 1'b1;
        repeat (20) queue_random_word();

        wait_quiet();
        repeat (SETTLE) @(posedge clk);
        if (bad_cnt == 0 && replies_due.size() == 0)
            $display("** first_fit_block_allocator_top: PASSED **");
        else
            $display("** first_fit_block_allocator_top: FAILED **");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("** first_fit_block_allocator_top: FAILED **");
        $finish;
    end

endmodule

/* first_fit_block_allocator_top.f */
src/ffba_pkg.sv
src/ffba_req_if.sv
src/ffba_rsp_if.sv
src/ffba_ram.sv
src/ffba_seq.sv
src/first_fit_block_allocator_top.sv
sim/first_fit_block_allocator_top_test.sv
